### sv/dlr_pkg.sv
// dlr_pkg: sizes, fixed-point formats and shared types of the dda line rasterizer
// no dependencies; imported by every module of the block
package dlr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int OFFSET_BITS = 10;
	localparam int OUT_BITS    = COORD_BITS + 1;
	localparam int ACC_W       = COORD_BITS + 1 + FRAC_BITS;
	localparam int STEP_W      = FRAC_BITS + 2;
	localparam int QUO_W       = FRAC_BITS + 1;
	localparam int CNT_W       = $clog2(FRAC_BITS + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(250);

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_STEP  = 1'b1
	} kind_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0] mag_t;

	// one classified item as it waits between front and back
	typedef struct packed {
		kind_t  kind;
		coord_t x1;
		coord_t y1;
		mag_t   adx;
		mag_t   ady;
		logic   sx;
		logic   sy;
		mag_t   steps;
	} item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

### sv/dlr_front.sv
// dlr_front: classifies accepted items, works out deltas, magnitudes and step count
// depends on dlr_pkg
module dlr_front (
	input  logic               push,
	input  logic               q_full,
	input  logic               kind,
	input  dlr_pkg::coord_t    start_x,
	input  dlr_pkg::coord_t    start_y,
	input  dlr_pkg::coord_t    end_x,
	input  dlr_pkg::coord_t    end_y,
	output logic               q_push,
	output dlr_pkg::item_t     q_item
);
	import dlr_pkg::*;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic [COORD_BITS:0] dx_abs;
	logic [COORD_BITS:0] dy_abs;
	mag_t adx;
	mag_t ady;

	always_comb begin
		dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
		dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
		dx_abs = dx[COORD_BITS] ? -dx : dx;
		dy_abs = dy[COORD_BITS] ? -dy : dy;
		adx = dx_abs[COORD_BITS-1:0];
		ady = dy_abs[COORD_BITS-1:0];
	end

	always_comb begin
		q_push = push && !q_full;
		q_item.kind = kind_t'(kind);
		q_item.x1 = start_x;
		q_item.y1 = start_y;
		q_item.adx = adx;
		q_item.ady = ady;
		q_item.sx = dx[COORD_BITS];
		q_item.sy = dy[COORD_BITS];
		q_item.steps = (adx > ady) ? adx : ady;
	end

endmodule

### sv/dlr_fifo.sv
// dlr_fifo: short item queue between front and back
// depends on dlr_pkg
module dlr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  dlr_pkg::item_t wr_item,
	input  logic           rd_en,
	output dlr_pkg::item_t rd_item,
	output logic           q_full,
	output logic           q_empty
);
	import dlr_pkg::*;

	item_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign q_full  = (count_q == QCNT_W'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/dlr_div.sv
// dlr_div: radix-2 restoring divider, both axes at once, one quotient bit per cycle
// depends on dlr_pkg
module dlr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  dlr_pkg::mag_t             adx,
	input  dlr_pkg::mag_t             ady,
	input  dlr_pkg::mag_t             steps,
	output dlr_pkg::div_status_t      status,
	output logic [dlr_pkg::QUO_W-1:0] qx,
	output logic [dlr_pkg::QUO_W-1:0] qy
);
	import dlr_pkg::*;

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	mag_t rx_q;
	mag_t ry_q;
	mag_t steps_q;
	logic [QUO_W-1:0] qx_q;
	logic [QUO_W-1:0] qy_q;

	logic first;
	logic [COORD_BITS:0] tx;
	logic [COORD_BITS:0] ty;
	logic [COORD_BITS:0] sx_sub;
	logic [COORD_BITS:0] sy_sub;
	logic bx;
	logic by;

	// first iteration gives the integer bit, the rest give fraction bits
	always_comb begin
		first  = (cnt_q == CNT_W'(FRAC_BITS));
		tx     = first ? {1'b0, rx_q} : {rx_q, 1'b0};
		ty     = first ? {1'b0, ry_q} : {ry_q, 1'b0};
		sx_sub = tx - {1'b0, steps_q};
		sy_sub = ty - {1'b0, steps_q};
		bx     = (tx >= {1'b0, steps_q});
		by     = (ty >= {1'b0, steps_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rx_q    <= adx;
			ry_q    <= ady;
			steps_q <= steps;
			qx_q    <= '0;
			qy_q    <= '0;
		end else if (busy_q) begin
			rx_q <= bx ? sx_sub[COORD_BITS-1:0] : tx[COORD_BITS-1:0];
			ry_q <= by ? sy_sub[COORD_BITS-1:0] : ty[COORD_BITS-1:0];
			qx_q <= {qx_q[QUO_W-2:0], bx};
			qy_q <= {qy_q[QUO_W-2:0], by};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign qx = qx_q;
	assign qy = qy_q;

endmodule

### sv/dlr_back.sv
// dlr_back: runs queued items, holds accumulators, offset register and result register
// depends on dlr_pkg and dlr_div
module dlr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [dlr_pkg::OFFSET_BITS-1:0] cfg_data,
	input  dlr_pkg::item_t                  q_item,
	input  logic                            q_empty,
	output logic                            q_pop,
	input  logic                            pop,
	output logic                            empty,
	output logic signed [dlr_pkg::OUT_BITS-1:0] pixel_x,
	output logic signed [dlr_pkg::OUT_BITS-1:0] pixel_y,
	output logic                            last_point
);
	import dlr_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_DIV = 2'b10
	} state_t;

	state_t state_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic signed [ACC_W-1:0] x_acc_q;
	logic signed [ACC_W-1:0] y_acc_q;
	logic signed [STEP_W-1:0] x_step_q;
	logic signed [STEP_W-1:0] y_step_q;
	mag_t steps_left_q;
	logic line_active_q;
	logic out_valid_q;
	logic signed [OUT_BITS-1:0] pixel_x_q;
	logic signed [OUT_BITS-1:0] pixel_y_q;
	logic last_q;
	logic sx_latched_q;
	logic sy_latched_q;

	div_status_t div_status;
	logic [QUO_W-1:0] qx;
	logic [QUO_W-1:0] qy;
	logic div_start;

	logic out_free;
	logic is_start;
	logic do_start;
	logic do_step;
	logic do_drop;
	logic emit;
	logic emit_last;
	logic signed [ACC_W-1:0] x_acc_d;
	logic signed [ACC_W-1:0] y_acc_d;
	logic signed [STEP_W-1:0] qx_ext;
	logic signed [STEP_W-1:0] qy_ext;

	function automatic logic signed [OUT_BITS-1:0] pix(
		input logic signed [ACC_W-1:0] acc,
		input logic [OFFSET_BITS-1:0] off
	);
		logic [OUT_BITS+OFFSET_BITS-1:0] sum;
		sum = {{OFFSET_BITS{acc[ACC_W-1]}}, acc[ACC_W-1:FRAC_BITS]}
			+ {{OUT_BITS{1'b0}}, off};
		return sum[OUT_BITS-1:0];
	endfunction

	dlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.adx    (q_item.adx),
		.ady    (q_item.ady),
		.steps  (q_item.steps),
		.status (div_status),
		.qx     (qx),
		.qy     (qy)
	);

	always_comb begin
		out_free  = !out_valid_q || pop;
		is_start  = (q_item.kind == KIND_START);
		do_start  = (state_q == ST_RUN) && !q_empty && is_start && out_free;
		do_step   = (state_q == ST_RUN) && !q_empty && !is_start && line_active_q && out_free;
		do_drop   = (state_q == ST_RUN) && !q_empty && !is_start && !line_active_q;
		q_pop     = do_start || do_step || do_drop;
		emit      = do_start || do_step;
		div_start = do_start && (q_item.steps != '0);
		emit_last = do_start ? (q_item.steps == '0) : (steps_left_q == mag_t'(1));

		if (do_start) begin
			x_acc_d = {q_item.x1[COORD_BITS-1], q_item.x1, {FRAC_BITS{1'b0}}};
			y_acc_d = {q_item.y1[COORD_BITS-1], q_item.y1, {FRAC_BITS{1'b0}}};
		end else begin
			x_acc_d = x_acc_q + {{(ACC_W-STEP_W){x_step_q[STEP_W-1]}}, x_step_q};
			y_acc_d = y_acc_q + {{(ACC_W-STEP_W){y_step_q[STEP_W-1]}}, y_step_q};
		end

		qx_ext = {1'b0, qx};
		qy_ext = {1'b0, qy};
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			x_acc_q   <= x_acc_d;
			y_acc_q   <= y_acc_d;
			pixel_x_q <= pix(x_acc_d, offset_q);
			pixel_y_q <= pix(y_acc_d, offset_q);
			last_q    <= emit_last;
		end
		if (do_start) begin
			steps_left_q <= q_item.steps;
		end else if (do_step) begin
			steps_left_q <= steps_left_q - 1'b1;
		end
	end

	// signs are latched with the divider operands, the item leaves the queue at start
	always_ff @(posedge clk) begin
		if (div_start) begin
			sx_latched_q <= q_item.sx;
			sy_latched_q <= q_item.sy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_RUN;
			offset_q      <= OFFSET_RESET;
			line_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
			x_step_q      <= '0;
			y_step_q      <= '0;
		end else begin
			if (cfg_valid) begin
				offset_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (do_start) begin
				line_active_q <= (q_item.steps != '0);
			end else if (do_step) begin
				line_active_q <= (steps_left_q != mag_t'(1));
			end
			case (state_q)
				ST_RUN: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_status.done) begin
						x_step_q <= sx_latched_q ? -qx_ext : qx_ext;
						y_step_q <= sy_latched_q ? -qy_ext : qy_ext;
						state_q  <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign empty      = !out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_point = last_q;

endmodule

### sv/dda_line_rasterizer_top.sv
// dda_line_rasterizer_top: dda line rasterizer, front classifier, item queue, stepping back end
// depends on dlr_pkg, dlr_front, dlr_fifo, dlr_back (which holds dlr_div)
//
// channel   handshake            beat
// input     push / full          kind, start_x, start_y, end_x, end_y
// result    pop / empty          pixel_x, pixel_y, last_point
// config    cfg_valid/cfg_ready  cfg_data (screen_offset)
//
// a step item gives one point per cycle while no divide runs and the result register is free.
// a start item with distinct endpoints emits its first point at once, then holds the back
// end while the shared divider makes one increment bit per cycle per axis.
// a two-entry queue lets input beats land while the back end divides or the result waits.
// reset clears control state, the queue and the offset to 250; no clearing pass is needed.
module dda_line_rasterizer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            kind,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end_y,
	input  logic                            pop,
	output logic                            empty,
	output logic signed [dlr_pkg::OUT_BITS-1:0] pixel_x,
	output logic signed [dlr_pkg::OUT_BITS-1:0] pixel_y,
	output logic                            last_point,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dlr_pkg::OFFSET_BITS-1:0] cfg_data
);
	import dlr_pkg::*;

	logic q_push;
	item_t q_wr_item;
	item_t q_rd_item;
	logic q_pop;
	logic q_empty;

	assign cfg_ready = 1'b1;

	dlr_front u_front (
		.push    (push),
		.q_full  (full),
		.kind    (kind),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.q_push  (q_push),
		.q_item  (q_wr_item)
	);

	dlr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_wr_item),
		.rd_en   (q_pop),
		.rd_item (q_rd_item),
		.q_full  (full),
		.q_empty (q_empty)
	);

	dlr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.q_item     (q_rd_item),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_point (last_point)
	);

endmodule

### tb/tb_dda_line_rasterizer_top.sv
// tb_dda_line_rasterizer_top: self-checking bench for the dda line rasterizer top level
// depends on dlr_pkg and dda_line_rasterizer_top; a local fixed-point model predicts every point
// stimulus: directed corner lines, then random lines under four screen offsets
`timescale 1ns / 1ps

module tb_dda_line_rasterizer_top;
	import dlr_pkg::*;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [STEP_W-1:0] inc_t;

	typedef struct {
		kind_t  kind;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} line_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] px;
		logic signed [OUT_BITS-1:0] py;
		logic                       last;
	} point_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	logic                   kind = KIND_START;
	coord_t                 start_x = '0;
	coord_t                 start_y = '0;
	coord_t                 end_x = '0;
	coord_t                 end_y = '0;
	logic                   pop = 1'b0;
	logic                   empty;
	logic signed [OUT_BITS-1:0] pixel_x;
	logic signed [OUT_BITS-1:0] pixel_y;
	logic                   last_point;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [OFFSET_BITS-1:0] cfg_data = '0;

	dda_line_rasterizer_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.pop        (pop),
		.empty      (empty),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_point (last_point),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// line state mirrored from the block
	acc_t                   x_acc = '0;
	acc_t                   y_acc = '0;
	inc_t                   x_inc = '0;
	inc_t                   y_inc = '0;
	logic [OUT_BITS-1:0]    steps_to_go = '0;
	logic                   drawing = 1'b0;
	logic [OFFSET_BITS-1:0] line_offset = OFFSET_RESET;

	line_item_t pending_items[$];
	point_t     expected_points[$];

	bit in_fire = 1'b0;
	bit cfg_fire = 1'b0;
	int burst_left = 8;
	int gap_left = 0;
	int pop_mode = 0;
	int pop_mode_left = 0;
	int errors = 0;
	int lines_started = 0;
	int points_checked = 0;
	int offsets_used = 1;

	function automatic point_t plot_point(input logic last);
		point_t p;
		int fx, fy, off;
		off = int'(line_offset);
		fx = int'(x_acc >>> FRAC_BITS);
		fy = int'(y_acc >>> FRAC_BITS);
		p.px = OUT_BITS'(off + fx);
		p.py = OUT_BITS'(off + fy);
		p.last = last;
		return p;
	endfunction

	// signed increment, truncated toward zero
	function automatic inc_t slope(input int d, input int span);
		int mag, q;
		mag = (d < 0) ? -d : d;
		q = (mag << FRAC_BITS) / span;
		return (d < 0) ? inc_t'(-q) : inc_t'(q);
	endfunction

	task automatic rasterize(input line_item_t it);
		int x1, y1, dx, dy, adx, ady, span;
		if (it.kind == KIND_START) begin
			x1 = int'(it.sx);
			y1 = int'(it.sy);
			dx = int'(it.ex) - x1;
			dy = int'(it.ey) - y1;
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			span = (adx > ady) ? adx : ady;
			x_acc = acc_t'(x1 * (1 << FRAC_BITS));
			y_acc = acc_t'(y1 * (1 << FRAC_BITS));
			if (span == 0) begin
				x_inc = '0;
				y_inc = '0;
				steps_to_go = '0;
				drawing = 1'b0;
				expected_points.push_back(plot_point(1'b1));
			end else begin
				x_inc = slope(dx, span);
				y_inc = slope(dy, span);
				steps_to_go = OUT_BITS'(span);
				drawing = 1'b1;
				expected_points.push_back(plot_point(1'b0));
			end
			lines_started++;
		end else if (drawing) begin
			x_acc = x_acc + acc_t'(x_inc);
			y_acc = y_acc + acc_t'(y_inc);
			steps_to_go = steps_to_go - 1'b1;
			if (steps_to_go == 0)
				drawing = 1'b0;
			expected_points.push_back(plot_point(steps_to_go == 0));
		end
	endtask

	// monitor: results are checked before the beat taken at the same edge is predicted
	always @(posedge clk) begin : monitor
		point_t got, want;
		line_item_t it;
		in_fire = arst_n && push && !full;
		cfg_fire = arst_n && cfg_valid && cfg_ready;
		if (arst_n && pop && !empty) begin
			got.px = pixel_x;
			got.py = pixel_y;
			got.last = last_point;
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected point, expected none actual x=%0d y=%0d last=%0b",
					$time, got.px, got.py, got.last);
			end else begin
				want = expected_points.pop_front();
				points_checked++;
				if (got !== want) begin
					errors++;
					$display("%0t: point mismatch, expected x=%0d y=%0d last=%0b actual x=%0d y=%0d last=%0b",
						$time, want.px, want.py, want.last, got.px, got.py, got.last);
				end
			end
		end
		if (in_fire) begin
			it.kind = kind_t'(kind);
			it.sx = start_x;
			it.sy = start_y;
			it.ex = end_x;
			it.ey = end_y;
			rasterize(it);
		end
		if (cfg_fire)
			line_offset = cfg_data;
	end

	// sender: bursts of beats with random gaps
	always @(negedge clk) begin : driver
		line_item_t it;
		if (arst_n && (!push || in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				kind <= it.kind;
				start_x <= it.sx;
				start_y <= it.sy;
				end_x <= it.ex;
				end_y <= it.ey;
				push <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: switches between draining, random and mostly stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop_mode_left == 0) begin
				pop_mode = $urandom_range(0, 2);
				pop_mode_left = $urandom_range(8, 60);
			end
			pop_mode_left--;
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				default: pop <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic coord_t clamp_coord(input int v);
		if (v > 2047)
			return coord_t'(2047);
		if (v < -2048)
			return coord_t'(-2048);
		return coord_t'(v);
	endfunction

	task automatic queue_item(input kind_t k, input int sx, input int sy, input int ex,
			input int ey);
		line_item_t it;
		it.kind = k;
		it.sx = coord_t'(sx);
		it.sy = coord_t'(sy);
		it.ex = coord_t'(ex);
		it.ey = coord_t'(ey);
		pending_items.push_back(it);
	endtask

	// a start beat followed by n step beats; step beats carry random endpoint noise
	task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
			input int n);
		queue_item(KIND_START, sx, sy, ex, ey);
		repeat (n)
			queue_item(KIND_STEP, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic queue_random(input int target);
		int count, sx, sy, ex, ey, cls, span, adx, ady, n, r;
		coord_t c;
		count = 0;
		while (count < target) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				c = coord_t'($urandom);
				sx = int'(c);
				c = coord_t'($urandom);
				sy = int'(c);
				cls = $urandom_range(0, 99);
				if (cls < 80) begin
					ex = int'(clamp_coord(sx + $urandom_range(0, 24) - 12));
					ey = int'(clamp_coord(sy + $urandom_range(0, 24) - 12));
				end else if (cls < 95) begin
					ex = int'(clamp_coord(sx + $urandom_range(0, 120) - 60));
					ey = int'(clamp_coord(sy + $urandom_range(0, 120) - 60));
				end else begin
					c = coord_t'($urandom);
					ex = int'(c);
					c = coord_t'($urandom);
					ey = int'(c);
				end
				adx = (ex > sx) ? ex - sx : sx - ex;
				ady = (ey > sy) ? ey - sy : sy - ey;
				span = (adx > ady) ? adx : ady;
				r = $urandom_range(0, 99);
				if (r < 70)
					n = span;
				else if (r < 85)
					n = span + $urandom_range(1, 3);
				else
					n = (span > 0) ? $urandom_range(0, span - 1) : 0;
				// long lines are cut short and dropped by the next start
				if (n > 60)
					n = $urandom_range(2, 30);
				queue_line(sx, sy, ex, ey, n);
				count += 1 + ((n < span) ? n : span);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 3))
					queue_item(KIND_STEP, $urandom, $urandom, $urandom, $urandom);
			end else begin
				c = coord_t'($urandom);
				sx = int'(c);
				c = coord_t'($urandom);
				sy = int'(c);
				queue_line(sx, sy, sx, sy, 0);
				count++;
			end
		end
	endtask

	// all beats taken, all points back, then room for a divide still in flight
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || push || expected_points.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_offset(input logic [OFFSET_BITS-1:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(negedge clk);
		while (!cfg_fire);
		cfg_valid <= 1'b0;
		offsets_used++;
	endtask

	initial begin
		int guard;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// step with no line in progress, then a single point at the coordinate extremes
		queue_item(KIND_STEP, -2048, 2047, -1, 0);
		queue_line(2047, -2048, 2047, -2048, 1);
		// shallow line plus one extra step after the last point
		queue_line(0, 0, 3, 1, 4);
		// full-range diagonal, dropped after two steps by a new start
		queue_line(-2048, 2047, 2047, -2048, 2);
		// steep line with negative increments, one extra step
		queue_line(5, 5, 2, -1, 7);
		// horizontal line at the left edge
		queue_line(-2048, 0, -2045, 0, 3);
		wait_idle();

		write_offset(OFFSET_BITS'(1023));
		queue_random(170);
		wait_idle();
		write_offset(OFFSET_BITS'(0));
		queue_random(170);
		wait_idle();
		write_offset(OFFSET_BITS'($urandom_range(1, 1022)));
		queue_random(170);
		wait_idle();
		write_offset(OFFSET_BITS'($urandom_range(1, 1022)));
		queue_random(170);

		guard = 0;
		do begin
			@(posedge clk);
			#1;
			guard++;
		end while ((pending_items.size() != 0 || push || expected_points.size() != 0)
			&& guard < 200000);
		repeat (40) @(posedge clk);
		if (expected_points.size() != 0) begin
			errors += expected_points.size();
			$display("%0t: %0d expected points never arrived", $time, expected_points.size());
		end
		$display("covered %0d line starts and %0d checked points under %0d screen offsets",
			lines_started, points_checked, offsets_used);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4ms;
		$display("%0t: run timed out", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule
